### sv/salc_pkg.sv
// ----------------------------------------------------------------------------
// salc_pkg
// Shared widths, codes and types for the set-associative LRU cache model.
// ----------------------------------------------------------------------------
package salc_pkg;

    // field widths
    localparam int ADDR_W       = 64;
    localparam int KIND_W       = 2;
    localparam int TAG_W        = 62;
    localparam int OUTCOME_W    = 2;
    localparam int CNT_W        = 32;
    localparam int OUT_DATA_W   = 104;

    // configuration port
    localparam int CFG_IDX_W    = 2;
    localparam int CFG_DATA_W   = 6;
    localparam int BLOCK_BITS_W = 6;
    localparam int BLOCK_BITS_MAX = 32;

    localparam logic [CFG_IDX_W-1:0] CFG_SET_BITS   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_WAYS       = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_BITS = 2'd2;

    // access kinds
    localparam logic [KIND_W-1:0] KIND_LOAD   = 2'd0;
    localparam logic [KIND_W-1:0] KIND_STORE  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_MODIFY = 2'd2;

    // outcome of the first access
    localparam logic [OUTCOME_W-1:0] OUT_HIT   = 2'd0;
    localparam logic [OUTCOME_W-1:0] OUT_FILL  = 2'd1;
    localparam logic [OUTCOME_W-1:0] OUT_EVICT = 2'd2;

    // lookup status handed from the set logic to the control
    typedef struct packed {
        logic                 hit;
        logic                 evict;
        logic [OUTCOME_W-1:0] outcome;
    } t_lookup_res;

endpackage

### sv/set_assoc_lru_cache_model.sv
// ----------------------------------------------------------------------------
// set_assoc_lru_cache_model
// Set-associative cache with LRU replacement and running hit, miss and
// eviction totals.
// ----------------------------------------------------------------------------
// Each input item is one access (tuser: kind, tdata: 64-bit address) and gives
// exactly one result item. The set row is read from the set memory on the cycle
// of acceptance; the updated row is written back, and the result registered, in
// the write-back step, which waits while an earlier result is not yet taken; a
// modify's second access is resolved in the same write-back since it always hits
// the line just touched. The result register lets a new item be taken while the
// previous result is still waiting. After reset the block clears the set memory,
// one set a cycle, through all 2**MAX_SET_BITS sets before it accepts its first
// item; configuration writes are taken at any time.
module set_assoc_lru_cache_model #(
    parameter int MAX_SET_BITS = 8,
    parameter int MAX_WAYS     = 8
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // configuration
    input  logic                                i_cfg_we,
    input  logic [salc_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [salc_pkg::CFG_DATA_W-1:0]     i_cfg_wdata,
    // access items
    input  logic                                i_s_tvalid,
    output logic                                o_s_tready,
    input  logic [salc_pkg::ADDR_W-1:0]         i_s_tdata,  // [63:0] address
    input  logic [salc_pkg::KIND_W-1:0]         i_s_tuser,  // [1:0] kind
    // result items
    output logic                                o_m_tvalid,
    input  logic                                i_m_tready,
    // [1:0] outcome, [2] second_hit, [34:3] hit_total, [66:35] miss_total,
    // [98:67] eviction_total, [103:99] zero
    output logic [salc_pkg::OUT_DATA_W-1:0]     o_m_tdata
);
    import salc_pkg::*;

    localparam int AGE_W  = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
    localparam int NW_W   = $clog2(MAX_WAYS + 1);
    localparam int SB_W   = $clog2(MAX_SET_BITS + 1);
    localparam int SET_W  = MAX_SET_BITS;
    localparam int SUM_W  = 7;
    localparam int ROW_W  = MAX_WAYS * (1 + AGE_W + TAG_W);
    localparam int PAD_W  = OUT_DATA_W - (OUTCOME_W + 1 + 3 * CNT_W);

    localparam logic [1:0] ST_CLEAR = 2'd0;
    localparam logic [1:0] ST_IDLE  = 2'd1;
    localparam logic [1:0] ST_EXEC  = 2'd2;

    // saturating counter step
    function automatic logic [CNT_W-1:0] sat_add(input logic [CNT_W-1:0] cnt,
                                                 input logic [1:0] inc);
        logic [CNT_W:0] sum;
        sum = {1'b0, cnt} + (CNT_W + 1)'(inc);
        return sum[CNT_W] ? '1 : sum[CNT_W-1:0];
    endfunction

    // configuration registers, held already clamped
    logic [SB_W-1:0]         r_set_bits;
    logic [NW_W-1:0]         r_ways;
    logic [BLOCK_BITS_W-1:0] r_block_bits;

    // control and item registers
    logic [1:0]              r_state;
    logic [1:0]              n_state;
    logic [SET_W-1:0]        r_clr_addr;
    logic [SET_W-1:0]        r_set;
    logic [TAG_W-1:0]        r_tag;
    logic [KIND_W-1:0]       r_kind;
    logic [CNT_W-1:0]        r_hit_cnt;
    logic [CNT_W-1:0]        r_miss_cnt;
    logic [CNT_W-1:0]        r_evict_cnt;
    logic                    r_out_valid;
    logic [OUT_DATA_W-1:0]   r_out_data;

    logic                    accept;
    logic                    exec_go;
    logic                    second;
    logic [ADDR_W-1:0]       addr_shift;
    logic [ADDR_W-1:0]       tag_full;
    logic [SET_W-1:0]        set_mask;
    logic [SET_W-1:0]        set_idx;
    logic [SUM_W-1:0]        tag_shift;
    logic [CNT_W-1:0]        n_hit_cnt;
    logic [CNT_W-1:0]        n_miss_cnt;
    logic [CNT_W-1:0]        n_evict_cnt;

    logic                    mem_we;
    logic [SET_W-1:0]        mem_waddr;
    logic [ROW_W-1:0]        mem_wdata;
    logic [ROW_W-1:0]        mem_rdata;

    logic [MAX_WAYS-1:0]                 rd_valid;
    logic [MAX_WAYS-1:0][AGE_W-1:0]      rd_ages;
    logic [MAX_WAYS-1:0][TAG_W-1:0]      rd_tags;
    logic [MAX_WAYS-1:0]                 wr_valid;
    logic [MAX_WAYS-1:0][AGE_W-1:0]      wr_ages;
    logic [MAX_WAYS-1:0][TAG_W-1:0]      wr_tags;
    t_lookup_res                         res;

    // configuration writes, clamped to the legal ranges
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_set_bits   <= SB_W'(1);
            r_ways       <= NW_W'(1);
            r_block_bits <= BLOCK_BITS_W'(1);
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_SET_BITS: begin
                    if (i_cfg_wdata[3:0] == 4'd0) begin
                        r_set_bits <= SB_W'(1);
                    end else if (int'(i_cfg_wdata[3:0]) > MAX_SET_BITS) begin
                        r_set_bits <= SB_W'(MAX_SET_BITS);
                    end else begin
                        r_set_bits <= SB_W'(i_cfg_wdata[3:0]);
                    end
                end
                CFG_WAYS: begin
                    if (i_cfg_wdata[3:0] == 4'd0) begin
                        r_ways <= NW_W'(1);
                    end else if (int'(i_cfg_wdata[3:0]) > MAX_WAYS) begin
                        r_ways <= NW_W'(MAX_WAYS);
                    end else begin
                        r_ways <= NW_W'(i_cfg_wdata[3:0]);
                    end
                end
                CFG_BLOCK_BITS: begin
                    if (i_cfg_wdata == '0) begin
                        r_block_bits <= BLOCK_BITS_W'(1);
                    end else if (int'(i_cfg_wdata) > BLOCK_BITS_MAX) begin
                        r_block_bits <= BLOCK_BITS_W'(BLOCK_BITS_MAX);
                    end else begin
                        r_block_bits <= i_cfg_wdata;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // address split into set index and tag
    always_comb begin
        addr_shift = i_s_tdata >> r_block_bits;
        set_mask   = ~({SET_W{1'b1}} << r_set_bits);
        set_idx    = addr_shift[SET_W-1:0] & set_mask;
        tag_shift  = SUM_W'(r_set_bits) + SUM_W'(r_block_bits);
        tag_full   = i_s_tdata >> tag_shift;
    end

    assign accept     = i_s_tvalid && o_s_tready;
    assign o_s_tready = (r_state == ST_IDLE);
    assign exec_go    = (r_state == ST_EXEC) && (!r_out_valid || i_m_tready);
    assign second     = (r_kind == KIND_MODIFY);

    // state sequencing
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_CLEAR: begin
                if (r_clr_addr == '1) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (accept) begin
                    n_state = ST_EXEC;
                end
            end
            ST_EXEC: begin
                if (exec_go) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_CLEAR;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_CLEAR;
            r_clr_addr <= '0;
        end else begin
            r_state <= n_state;
            if (r_state == ST_CLEAR) begin
                r_clr_addr <= r_clr_addr + SET_W'(1);
            end
        end
    end

    // item fields held for the write-back
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_set  <= set_idx;
            r_tag  <= tag_full[TAG_W-1:0];
            r_kind <= i_s_tuser;
        end
    end

    // set memory: clearing pass or write-back of the updated set
    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = r_set;
        mem_wdata = {wr_valid, wr_ages, wr_tags};
        if (r_state == ST_CLEAR) begin
            mem_we    = 1'b1;
            mem_waddr = r_clr_addr;
            mem_wdata = '0;
        end else if (exec_go) begin
            mem_we = 1'b1;
        end
    end

    salc_set_mem #(
        .ADDR_BITS (SET_W),
        .DATA_BITS (ROW_W)
    ) u_set_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_re    (accept),
        .i_raddr (set_idx),
        .o_rdata (mem_rdata)
    );

    assign {rd_valid, rd_ages, rd_tags} = mem_rdata;

    salc_lookup #(
        .MAX_WAYS (MAX_WAYS),
        .AGE_W    (AGE_W),
        .NW_W     (NW_W)
    ) u_lookup (
        .i_valid (rd_valid),
        .i_ages  (rd_ages),
        .i_tags  (rd_tags),
        .i_tag   (r_tag),
        .i_nw    (r_ways),
        .o_valid (wr_valid),
        .o_ages  (wr_ages),
        .o_tags  (wr_tags),
        .o_res   (res)
    );

    // running totals, a modify adds its second hit
    always_comb begin
        n_hit_cnt   = sat_add(r_hit_cnt, {1'b0, res.hit} + {1'b0, second});
        n_miss_cnt  = sat_add(r_miss_cnt, {1'b0, !res.hit});
        n_evict_cnt = sat_add(r_evict_cnt, {1'b0, res.evict});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hit_cnt   <= '0;
            r_miss_cnt  <= '0;
            r_evict_cnt <= '0;
        end else if (exec_go) begin
            r_hit_cnt   <= n_hit_cnt;
            r_miss_cnt  <= n_miss_cnt;
            r_evict_cnt <= n_evict_cnt;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (exec_go) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (exec_go) begin
            r_out_data <= {PAD_W'(0), n_evict_cnt, n_miss_cnt, n_hit_cnt,
                           second, res.outcome};
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;

`ifndef SYNTHESIS
    // an accepted item is always followed by its write-back step
    a_accept_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> (r_state == ST_EXEC))
        else $error("accepted item did not reach write-back");

    // a result only appears from a write-back step
    a_result_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_m_tvalid) |-> ($past(r_state) == ST_EXEC))
        else $error("result without write-back");

    // evictions are a subset of misses
    a_evict_le_miss: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_evict_cnt <= r_miss_cnt)
        else $error("eviction total above miss total");

    // no item is taken while the set memory is being cleared
    a_no_accept_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_CLEAR) |=> !$past(accept))
        else $error("item accepted during clearing pass");
`endif

endmodule

### sv/salc_set_mem.sv
// ----------------------------------------------------------------------------
// salc_set_mem
// Synchronous set memory: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module salc_set_mem #(
    parameter int ADDR_BITS = 8,
    parameter int DATA_BITS = 8
) (
    input  logic                 i_clk,
    input  logic                 i_we,
    input  logic [ADDR_BITS-1:0] i_waddr,
    input  logic [DATA_BITS-1:0] i_wdata,
    input  logic                 i_re,
    input  logic [ADDR_BITS-1:0] i_raddr,
    output logic [DATA_BITS-1:0] o_rdata
);

    logic [DATA_BITS-1:0] r_mem [2**ADDR_BITS];
    logic [DATA_BITS-1:0] r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // read port, data held until the next read
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### sv/salc_lookup.sv
// ----------------------------------------------------------------------------
// salc_lookup
// Tag match, fill and victim choice for one set, and the updated LRU ranks.
// ----------------------------------------------------------------------------
module salc_lookup #(
    parameter int MAX_WAYS = 8,
    parameter int AGE_W    = 3,
    parameter int NW_W     = 4
) (
    input  logic [MAX_WAYS-1:0]                       i_valid,
    input  logic [MAX_WAYS-1:0][AGE_W-1:0]            i_ages,
    input  logic [MAX_WAYS-1:0][salc_pkg::TAG_W-1:0]  i_tags,
    input  logic [salc_pkg::TAG_W-1:0]                i_tag,
    input  logic [NW_W-1:0]                           i_nw,
    output logic [MAX_WAYS-1:0]                       o_valid,
    output logic [MAX_WAYS-1:0][AGE_W-1:0]            o_ages,
    output logic [MAX_WAYS-1:0][salc_pkg::TAG_W-1:0]  o_tags,
    output salc_pkg::t_lookup_res                     o_res
);
    import salc_pkg::*;

    localparam logic [AGE_W-1:0] AGE_SAT = AGE_W'(MAX_WAYS - 1);

    logic [MAX_WAYS-1:0] in_use;
    logic [MAX_WAYS-1:0] match;
    logic [MAX_WAYS-1:0] empty;
    logic [MAX_WAYS-1:0] cand;
    logic [AGE_W-1:0]    hit_way;
    logic [AGE_W-1:0]    empty_way;
    logic [AGE_W-1:0]    vic_way;
    logic [AGE_W-1:0]    tgt_way;
    logic [AGE_W-1:0]    limit;
    logic                age_all;

    // per-way match, free slot and victim candidacy
    always_comb begin
        for (int i = 0; i < MAX_WAYS; i++) begin
            in_use[i] = (NW_W'(i) < i_nw);
            match[i]  = in_use[i] && i_valid[i] && (i_tags[i] == i_tag);
            empty[i]  = in_use[i] && !i_valid[i];
            // oldest way, lowest index on a tie
            cand[i]   = in_use[i];
            for (int j = 0; j < MAX_WAYS; j++) begin
                if (in_use[j] && (j < i) && (i_ages[j] >= i_ages[i])) begin
                    cand[i] = 1'b0;
                end
                if (in_use[j] && (j > i) && (i_ages[j] > i_ages[i])) begin
                    cand[i] = 1'b0;
                end
            end
        end
    end

    // lowest-index selection of each kind of way
    always_comb begin
        hit_way   = '0;
        empty_way = '0;
        vic_way   = '0;
        for (int i = MAX_WAYS - 1; i >= 0; i--) begin
            if (match[i]) begin
                hit_way = AGE_W'(i);
            end
            if (empty[i]) begin
                empty_way = AGE_W'(i);
            end
            if (cand[i]) begin
                vic_way = AGE_W'(i);
            end
        end
    end

    // outcome and the way that becomes most recent
    always_comb begin
        o_res   = '0;
        age_all = 1'b0;
        priority if (|match) begin
            tgt_way       = hit_way;
            limit         = i_ages[hit_way];
            o_res.hit     = 1'b1;
            o_res.outcome = OUT_HIT;
        end else if (|empty) begin
            tgt_way       = empty_way;
            limit         = '0;
            age_all       = 1'b1;
            o_res.outcome = OUT_FILL;
        end else begin
            tgt_way       = vic_way;
            limit         = i_ages[vic_way];
            o_res.evict   = 1'b1;
            o_res.outcome = OUT_EVICT;
        end
    end

    // aged ranks and the rewritten line
    always_comb begin
        o_valid = i_valid;
        o_tags  = i_tags;
        o_ages  = i_ages;
        for (int i = 0; i < MAX_WAYS; i++) begin
            if (in_use[i] && i_valid[i] && (age_all || (i_ages[i] < limit))
                    && (i_ages[i] < AGE_SAT)) begin
                o_ages[i] = i_ages[i] + AGE_W'(1);
            end
        end
        o_valid[tgt_way] = 1'b1;
        o_tags[tgt_way]  = i_tag;
        o_ages[tgt_way]  = '0;
    end

endmodule

### test/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the set-associative LRU cache model: drives access
// items through the stream port, keeps a shadow copy of tags, LRU ranks and
// running totals, and compares every result item field by field.
// ----------------------------------------------------------------------------
module testbench;
    import salc_pkg::*;

    localparam int MAX_SET_BITS   = 8;
    localparam int MAX_WAYS       = 8;
    localparam int NUM_LINES      = (1 << MAX_SET_BITS) * MAX_WAYS;
    localparam int DIRECTED_N     = 22;
    localparam int PHASES         = 12;
    localparam int ITEMS_PER_PHASE = 111;
    localparam int CYCLE_LIMIT    = 200000;

    // codes with no name in the package
    localparam logic [KIND_W-1:0]    KIND_UNUSED = 2'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE   = 2'd3;

    // fields of one result item
    typedef struct packed {
        logic [OUTCOME_W-1:0] outcome;
        logic                 second_hit;
        logic [CNT_W-1:0]     hits;
        logic [CNT_W-1:0]     misses;
        logic [CNT_W-1:0]     evictions;
    } t_cache_result;

    // one row of the directed table
    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [ADDR_W-1:0] addr;
        logic              typed;
        t_cache_result     res;
    } t_stim_row;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_wdata = '0;
    logic                  i_s_tvalid = 1'b0;
    logic                  o_s_tready;
    logic [ADDR_W-1:0]     i_s_tdata = '0;   // [63:0] address
    logic [KIND_W-1:0]     i_s_tuser = '0;   // [1:0] kind
    logic                  o_m_tvalid;
    logic                  i_m_tready = 1'b0;
    // [1:0] outcome, [2] second_hit, [34:3] hit_total, [66:35] miss_total,
    // [98:67] eviction_total, [103:99] zero
    logic [OUT_DATA_W-1:0] o_m_tdata;

    // shadow of the cache contents and registers
    logic                  shadow_valid [NUM_LINES];
    logic [TAG_W-1:0]      shadow_tag [NUM_LINES];
    logic [2:0]            shadow_rank [NUM_LINES];
    logic [CNT_W-1:0]      total_hits = '0;
    logic [CNT_W-1:0]      total_misses = '0;
    logic [CNT_W-1:0]      total_evictions = '0;
    logic [3:0]            reg_set_bits = 4'd1;
    logic [3:0]            reg_ways = 4'd1;
    logic [5:0]            reg_block_bits = 6'd1;

    t_cache_result         pending_results [$];
    t_cache_result         oldest;
    logic [ADDR_W-1:0]     tag_pool [16];
    int                    send_idle_pct = 0;
    int                    recv_stall_pct = 0;
    int                    fail_count = 0;
    int                    cycle_count = 0;

    // register settings per phase: set_bits, ways, block_bits
    logic [5:0] phase_cfg [PHASES][3] = '{
        '{6'd0,  6'd0,  6'd0},
        '{6'd1,  6'd2,  6'd4},
        '{6'd63, 6'd63, 6'd63},
        '{6'd8,  6'd8,  6'd32},
        '{6'd2,  6'd4,  6'd6},
        '{6'd3,  6'd8,  6'd1},
        '{6'd1,  6'd1,  6'd32},
        '{6'd4,  6'd3,  6'd5},
        '{6'd8,  6'd5,  6'd12},
        '{6'd2,  6'd8,  6'd3},
        '{6'd5,  6'd6,  6'd20},
        '{6'd17, 6'd7,  6'd33}
    };

    // directed items under the reset geometry: one set bit, one way, one offset bit
    t_stim_row directed_rows [DIRECTED_N] = '{
        '{KIND_LOAD,   64'h0000_0000_0000_0000, 1'b1, '{OUT_FILL,  1'b0, 32'd0, 32'd1, 32'd0}},
        '{KIND_LOAD,   64'h0000_0000_0000_0001, 1'b1, '{OUT_HIT,   1'b0, 32'd1, 32'd1, 32'd0}},
        '{KIND_MODIFY, 64'h0000_0000_0000_0000, 1'b1, '{OUT_HIT,   1'b1, 32'd3, 32'd1, 32'd0}},
        '{KIND_LOAD,   64'hFFFF_FFFF_FFFF_FFFF, 1'b1, '{OUT_FILL,  1'b0, 32'd3, 32'd2, 32'd0}},
        '{KIND_STORE,  64'hFFFF_FFFF_FFFF_FFFE, 1'b1, '{OUT_HIT,   1'b0, 32'd4, 32'd2, 32'd0}},
        '{KIND_LOAD,   64'hFFFF_FFFF_FFFF_FFFD, 1'b1, '{OUT_EVICT, 1'b0, 32'd4, 32'd3, 32'd1}},
        '{KIND_MODIFY, 64'h0000_0000_0000_0004, 1'b1, '{OUT_EVICT, 1'b1, 32'd5, 32'd4, 32'd2}},
        '{KIND_UNUSED, 64'h0000_0000_0000_0004, 1'b1, '{OUT_HIT,   1'b0, 32'd6, 32'd4, 32'd2}},
        '{KIND_UNUSED, 64'h0000_0000_0000_0008, 1'b1, '{OUT_EVICT, 1'b0, 32'd6, 32'd5, 32'd3}},
        '{KIND_MODIFY, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1, '{OUT_HIT,   1'b1, 32'd8, 32'd5, 32'd3}},
        '{KIND_STORE,  64'h8000_0000_0000_0002, 1'b1, '{OUT_EVICT, 1'b0, 32'd8, 32'd6, 32'd4}},
        '{KIND_LOAD,   64'h5555_5555_5555_5555, 1'b1, '{OUT_EVICT, 1'b0, 32'd8, 32'd7, 32'd5}},
        '{KIND_LOAD,   64'hAAAA_AAAA_AAAA_AAAA, 1'b1, '{OUT_EVICT, 1'b0, 32'd8, 32'd8, 32'd6}},
        '{KIND_LOAD,   64'h5555_5555_5555_5554, 1'b1, '{OUT_HIT,   1'b0, 32'd9, 32'd8, 32'd6}},
        '{KIND_STORE,  64'hAAAA_AAAA_AAAA_AAAB, 1'b0, '0},
        '{KIND_MODIFY, 64'h1234_5678_9ABC_DEF0, 1'b0, '0},
        '{KIND_LOAD,   64'h7FFF_FFFF_FFFF_FFFF, 1'b0, '0},
        '{KIND_STORE,  64'h8000_0000_0000_0000, 1'b0, '0},
        '{KIND_MODIFY, 64'h8000_0000_0000_0000, 1'b0, '0},
        '{KIND_UNUSED, 64'hFFFF_FFFF_0000_0000, 1'b0, '0},
        '{KIND_STORE,  64'h0000_0000_FFFF_FFFF, 1'b0, '0},
        '{KIND_LOAD,   64'h0000_0000_FFFF_FFFF, 1'b0, '0}
    };

    set_assoc_lru_cache_model #(
        .MAX_SET_BITS(MAX_SET_BITS),
        .MAX_WAYS(MAX_WAYS)
    ) dut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_we),
        .i_cfg_index(i_cfg_index),
        .i_cfg_wdata(i_cfg_wdata),
        .i_s_tvalid(i_s_tvalid),
        .o_s_tready(o_s_tready),
        .i_s_tdata(i_s_tdata),
        .i_s_tuser(i_s_tuser),
        .o_m_tvalid(o_m_tvalid),
        .i_m_tready(i_m_tready),
        .o_m_tdata(o_m_tdata)
    );

    // clock
    always #4 i_clk = ~i_clk;

    function automatic int clamp_int(input int v, input int lo, input int hi);
        if (v < lo) return lo;
        if (v > hi) return hi;
        return v;
    endfunction

    function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] c);
        return (c == '1) ? c : c + 1'b1;
    endfunction

    // push down every valid line in the set ranked below the limit, saturating
    function automatic void age_lines(input int base, input int nw, input int limit);
        for (int i = 0; i < nw; i++) begin
            if (shadow_valid[base + i] && int'(shadow_rank[base + i]) < limit &&
                int'(shadow_rank[base + i]) < MAX_WAYS - 1) begin
                shadow_rank[base + i] = shadow_rank[base + i] + 3'd1;
            end
        end
    endfunction

    // one lookup with fill or LRU eviction on a miss
    function automatic logic [OUTCOME_W-1:0] cache_access(input logic [ADDR_W-1:0] addr);
        int sb;
        int nw;
        int bb;
        int base;
        int victim;
        int empty;
        logic [ADDR_W-1:0] tag;
        sb = clamp_int(int'(reg_set_bits), 1, MAX_SET_BITS);
        nw = clamp_int(int'(reg_ways), 1, MAX_WAYS);
        bb = clamp_int(int'(reg_block_bits), 1, BLOCK_BITS_MAX);
        base = int'((addr >> bb) & ((64'd1 << sb) - 64'd1)) * MAX_WAYS;
        tag = addr >> (sb + bb);
        empty = -1;
        for (int i = 0; i < nw; i++) begin
            if (shadow_valid[base + i] && shadow_tag[base + i] == tag[TAG_W-1:0]) begin
                age_lines(base, nw, int'(shadow_rank[base + i]));
                shadow_rank[base + i] = 3'd0;
                total_hits = sat_inc(total_hits);
                return OUT_HIT;
            end
            if (!shadow_valid[base + i] && empty < 0) empty = i;
        end
        total_misses = sat_inc(total_misses);
        if (empty >= 0) begin
            age_lines(base, nw, MAX_WAYS);
            shadow_valid[base + empty] = 1'b1;
            shadow_tag[base + empty] = tag[TAG_W-1:0];
            shadow_rank[base + empty] = 3'd0;
            return OUT_FILL;
        end
        // oldest way goes, lowest index on a tie
        victim = 0;
        for (int i = 1; i < nw; i++) begin
            if (shadow_rank[base + i] > shadow_rank[base + victim]) victim = i;
        end
        age_lines(base, nw, int'(shadow_rank[base + victim]));
        shadow_tag[base + victim] = tag[TAG_W-1:0];
        shadow_rank[base + victim] = 3'd0;
        total_evictions = sat_inc(total_evictions);
        return OUT_EVICT;
    endfunction

    // result of one access item; a modify repeats the access
    function automatic t_cache_result predict_cache_result(input logic [KIND_W-1:0] kind,
                                                           input logic [ADDR_W-1:0] addr);
        t_cache_result r;
        r.outcome = cache_access(addr);
        r.second_hit = 1'b0;
        if (kind == KIND_MODIFY) r.second_hit = (cache_access(addr) == OUT_HIT);
        r.hits = total_hits;
        r.misses = total_misses;
        r.evictions = total_evictions;
        return r;
    endfunction

    function automatic logic [KIND_W-1:0] pick_kind();
        int roll;
        roll = $urandom_range(0, 9);
        if (roll < 3) return KIND_LOAD;
        if (roll < 6) return KIND_STORE;
        if (roll < 9) return KIND_MODIFY;
        return KIND_UNUSED;
    endfunction

    // mostly a few tags over a few sets, so that hits and evictions are common
    function automatic logic [ADDR_W-1:0] pick_address();
        int sb;
        int nw;
        int bb;
        int roll;
        int set_idx;
        logic [ADDR_W-1:0] offset;
        sb = clamp_int(int'(reg_set_bits), 1, MAX_SET_BITS);
        nw = clamp_int(int'(reg_ways), 1, MAX_WAYS);
        bb = clamp_int(int'(reg_block_bits), 1, BLOCK_BITS_MAX);
        roll = $urandom_range(0, 99);
        if (roll < 10) return {$urandom, $urandom};
        if (roll < 50 && sb > 2) set_idx = $urandom_range(0, 3);
        else set_idx = $urandom_range(0, (1 << sb) - 1);
        offset = {$urandom, $urandom} & ((64'd1 << bb) - 64'd1);
        return (tag_pool[$urandom_range(0, nw + 2)] << (sb + bb)) |
               (64'(set_idx) << bb) | offset;
    endfunction

    task automatic check_field(input string name, input logic [63:0] want,
                               input logic [63:0] got);
        if (want !== got) begin
            $error("%s: expected %0h, got %0h", name, want, got);
            fail_count++;
        end
    endtask

    // offer one access item and hold it until taken
    task automatic send_access(input logic [KIND_W-1:0] kind, input logic [ADDR_W-1:0] addr,
                               input logic typed, input t_cache_result typed_res);
        t_cache_result predicted;
        while ($urandom_range(0, 99) < send_idle_pct) begin
            i_s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata <= addr;
        i_s_tuser <= kind;
        do @(posedge i_clk); while (!o_s_tready);
        predicted = predict_cache_result(kind, addr);
        pending_results.push_back(typed ? typed_res : predicted);
    endtask

    // stop offering items until every result has come back
    task automatic drain_results();
        i_s_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
    endtask

    task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [CFG_DATA_W-1:0] value);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        case (idx)
            CFG_SET_BITS:   reg_set_bits = value[3:0];
            CFG_WAYS:       reg_ways = value[3:0];
            CFG_BLOCK_BITS: reg_block_bits = value[5:0];
            default: ;
        endcase
    endtask

    // receiver stalls
    always @(posedge i_clk) begin
        i_m_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end

    // result checking against the oldest expectation
    always @(posedge i_clk) begin
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            if (pending_results.size() == 0) begin
                $error("result item with no access pending");
                fail_count++;
            end else begin
                oldest = pending_results.pop_front();
                check_field("outcome", 64'(oldest.outcome), 64'(o_m_tdata[1:0]));
                check_field("second_hit", 64'(oldest.second_hit), 64'(o_m_tdata[2]));
                check_field("hit_total", 64'(oldest.hits), 64'(o_m_tdata[34:3]));
                check_field("miss_total", 64'(oldest.misses), 64'(o_m_tdata[66:35]));
                check_field("eviction_total", 64'(oldest.evictions), 64'(o_m_tdata[98:67]));
                check_field("padding", 64'd0, 64'(o_m_tdata[103:99]));
            end
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("testbench: FAIL");
            $finish;
        end
    end

    // stimulus
    initial begin
        for (int k = 0; k < NUM_LINES; k++) begin
            shadow_valid[k] = 1'b0;
            shadow_rank[k] = 3'd0;
        end
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed table under the reset geometry
        for (int r = 0; r < DIRECTED_N; r++) begin
            send_access(directed_rows[r].kind, directed_rows[r].addr,
                        directed_rows[r].typed, directed_rows[r].res);
        end

        // random phases, each with its own geometry and idling pattern
        for (int p = 0; p < PHASES; p++) begin
            drain_results();
            write_register(CFG_SET_BITS, phase_cfg[p][0]);
            write_register(CFG_WAYS, phase_cfg[p][1]);
            write_register(CFG_BLOCK_BITS, phase_cfg[p][2]);
            if (p == 0) write_register(CFG_SPARE, 6'($urandom));
            i_cfg_we <= 1'b0;
            case (p % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 56; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 56; end
                default: begin send_idle_pct = 28; recv_stall_pct = 28; end
            endcase
            for (int t = 0; t < 16; t++) tag_pool[t] = (t < 8) ? 64'(t) : {$urandom, $urandom};
            for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
                if (p == 5 && n == 50) drain_results();
                send_access(pick_kind(), pick_address(), 1'b0, '0);
            end
        end

        // let the last results arrive
        drain_results();
        repeat (8) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("testbench: PASS");
        end else begin
            $display("testbench: FAIL");
        end
        $finish;
    end

endmodule
